/* rtl/core/bwd_pkg.sv */
// Shared types, codes and constants of the breakpoint/watch debug unit.
`timescale 1ns / 1ps

package bwd_pkg;

    localparam int CMD_W  = 3;
    localparam int ADDR_W = 16;
    localparam int KIND_W = 3;
    localparam int MODE_W = 2;

    localparam int BREAK_ENTRIES_DEF = 16;
    localparam int WATCH_ENTRIES_DEF = 16;
    localparam int ADDR_BITS_DEF     = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_FETCH     = 3'd0,
        CMD_ACCESS    = 3'd1,
        CMD_ADD_BREAK = 3'd2,
        CMD_ADD_WATCH = 3'd3,
        CMD_STEP_ON   = 3'd4,
        CMD_RESUME    = 3'd5,
        CMD_HALT      = 3'd6,
        CMD_RESET     = 3'd7
    } t_cmd;

    typedef enum logic [MODE_W-1:0] {
        MODE_RUN   = 2'd0,
        MODE_BREAK = 2'd1,
        MODE_HALT  = 2'd2
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        EV_NONE  = 3'd0,
        EV_BREAK = 3'd1,
        EV_WATCH = 3'd2,
        EV_STEP  = 3'd3,
        EV_EXIT  = 3'd4
    } t_event;

    // Status returned by an address table to the control logic.
    typedef struct packed {
        logic hit;
        logic full;
    } t_tab_status;

endpackage

/* rtl/core/bwd_cmd_if.sv */
// Command channel interface: valid, ready and the command beat payload.
`timescale 1ns / 1ps

interface bwd_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [bwd_pkg::CMD_W-1:0]   command;
    logic [bwd_pkg::ADDR_W-1:0]  address;

    modport source (output valid, command, address, input ready);
    modport sink   (input valid, command, address, output ready);
endinterface

/* rtl/core/bwd_res_if.sv */
// Result channel interface: valid, ready and the event beat payload.
`timescale 1ns / 1ps

interface bwd_res_if;
    logic                        valid;
    logic                        ready;
    logic [bwd_pkg::KIND_W-1:0]  event_kind;
    logic [bwd_pkg::ADDR_W-1:0]  event_address;
    logic                        status;
    logic [bwd_pkg::MODE_W-1:0]  mode_now;

    modport source (output valid, event_kind, event_address, status, mode_now, input ready);
    modport sink   (input valid, event_kind, event_address, status, mode_now, output ready);
endinterface

/* rtl/core/breakpoint_watch_debug_unit.sv */
// Top level of the breakpoint/watch debug unit: command register, decision logic, result register.
`timescale 1ns / 1ps

// Channel   Dir  Modport  Payload per beat
// i_cmd     in   sink     command[2:0], address[15:0]
// o_evt     out  source   event_kind[2:0], event_address[15:0], status, mode_now[1:0]
//
// One beat is taken per cycle while o_evt is not stalled, and every command beat yields exactly one result beat.
// A beat is captured in the command register, decided against the tables and the
// mode while it is held there, and is registered in the result register that drives o_evt.
// The decision uses the parallel comparators of the two tables, one compare per entry.
// Reset is synchronous: it empties both tables, selects run mode and clears stepping.
// A stall on o_evt holds the result register; the command register keeps taking a
// beat only while it is empty or moving on, so nothing is lost or doubled.

module breakpoint_watch_debug_unit #(
    parameter int BREAK_ENTRIES = bwd_pkg::BREAK_ENTRIES_DEF,
    parameter int WATCH_ENTRIES = bwd_pkg::WATCH_ENTRIES_DEF,
    parameter int ADDR_BITS     = bwd_pkg::ADDR_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bwd_cmd_if.sink   i_cmd,
    bwd_res_if.source o_evt
);

    // Only the low ADDR_BITS bits of the 16-bit address field take part.
    localparam int KEEP_W = (ADDR_BITS < bwd_pkg::ADDR_W) ? ADDR_BITS : bwd_pkg::ADDR_W;

    // Command register.
    logic                  r_in_valid;
    bwd_pkg::t_cmd         r_in_cmd;
    logic [KEEP_W-1:0]     r_in_addr;

    // Debug state.
    bwd_pkg::t_mode        r_mode;
    bwd_pkg::t_mode        n_mode;
    logic                  r_step;
    logic                  n_step;

    // Result register.
    logic                          r_out_valid;
    bwd_pkg::t_event               r_out_kind;
    logic [bwd_pkg::ADDR_W-1:0]    r_out_addr;
    logic                          r_out_status;
    bwd_pkg::t_mode                r_out_mode;

    // Decision outputs.
    bwd_pkg::t_event               n_kind;
    logic [bwd_pkg::ADDR_W-1:0]    n_ev_addr;
    logic                          n_status;
    logic                          bp_add;
    logic                          wt_add;

    bwd_pkg::t_tab_status          bp_stat;
    bwd_pkg::t_tab_status          wt_stat;

    logic                          advance;
    logic                          fire;

    // The result register moves on when it is empty or its beat is taken.
    assign advance     = !r_out_valid || o_evt.ready;
    assign fire        = r_in_valid && advance;
    assign i_cmd.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_cmd  <= bwd_pkg::t_cmd'(i_cmd.command);
            r_in_addr <= i_cmd.address[KEEP_W-1:0];
        end
    end

    bwd_addr_table #(
        .ENTRIES (BREAK_ENTRIES),
        .WIDTH   (KEEP_W)
    ) u_break_tab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_add   (bp_add),
        .i_addr  (r_in_addr),
        .o_stat  (bp_stat)
    );

    bwd_addr_table #(
        .ENTRIES (WATCH_ENTRIES),
        .WIDTH   (KEEP_W)
    ) u_watch_tab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_add   (wt_add),
        .i_addr  (r_in_addr),
        .o_stat  (wt_stat)
    );

    // Mode and step flag only change when the beat in the command register is decided.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bwd_pkg::MODE_RUN;
            r_step <= 1'b0;
        end else if (fire) begin
            r_mode <= n_mode;
            r_step <= n_step;
        end
    end

    // Next mode and the result of the beat held in the command register.
    always_comb begin
        n_mode    = r_mode;
        n_step    = r_step;
        n_kind    = bwd_pkg::EV_NONE;
        n_ev_addr = '0;
        n_status  = 1'b0;
        bp_add    = 1'b0;
        wt_add    = 1'b0;
        case (r_in_cmd)
            bwd_pkg::CMD_FETCH: begin
                case (r_mode)
                    bwd_pkg::MODE_HALT: begin
                        n_kind    = bwd_pkg::EV_EXIT;
                        n_ev_addr = bwd_pkg::ADDR_W'(r_in_addr);
                    end
                    bwd_pkg::MODE_BREAK: begin
                        if (r_step) begin
                            n_kind    = bwd_pkg::EV_STEP;
                            n_ev_addr = bwd_pkg::ADDR_W'(r_in_addr);
                        end else begin
                            n_mode = bwd_pkg::MODE_RUN;
                        end
                    end
                    bwd_pkg::MODE_RUN: begin
                        if (bp_stat.hit) begin
                            n_mode    = bwd_pkg::MODE_BREAK;
                            n_kind    = bwd_pkg::EV_BREAK;
                            n_ev_addr = bwd_pkg::ADDR_W'(r_in_addr);
                        end
                    end
                    default: begin
                        n_mode = r_mode;
                    end
                endcase
            end
            bwd_pkg::CMD_ACCESS: begin
                // A watched access breaks from any mode, halt included.
                if (wt_stat.hit) begin
                    n_mode    = bwd_pkg::MODE_BREAK;
                    n_kind    = bwd_pkg::EV_WATCH;
                    n_ev_addr = bwd_pkg::ADDR_W'(r_in_addr);
                end
            end
            bwd_pkg::CMD_ADD_BREAK: begin
                bp_add   = fire;
                n_status = bp_stat.full;
            end
            bwd_pkg::CMD_ADD_WATCH: begin
                wt_add   = fire;
                n_status = wt_stat.full;
            end
            bwd_pkg::CMD_STEP_ON: begin
                n_step = 1'b1;
            end
            bwd_pkg::CMD_RESUME: begin
                n_step = 1'b0;
                n_mode = bwd_pkg::MODE_RUN;
            end
            bwd_pkg::CMD_HALT: begin
                n_mode = bwd_pkg::MODE_HALT;
            end
            bwd_pkg::CMD_RESET: begin
                // Only the mode returns to run; stepping and tables stay.
                n_mode = bwd_pkg::MODE_RUN;
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_kind   <= n_kind;
            r_out_addr   <= n_ev_addr;
            r_out_status <= n_status;
            r_out_mode   <= n_mode;
        end
    end

    assign o_evt.valid         = r_out_valid;
    assign o_evt.event_kind    = r_out_kind;
    assign o_evt.event_address = r_out_addr;
    assign o_evt.status        = r_out_status;
    assign o_evt.mode_now      = r_out_mode;

    // A beat without an event carries a zero address.
    a_none_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == bwd_pkg::EV_NONE)) |-> (r_out_addr == '0))
        else $error("event address set on a result without an event");

    // A full-table report never comes with an event.
    a_full_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |-> (r_out_kind == bwd_pkg::EV_NONE))
        else $error("table full reported together with an event");

    // Breakpoint and watch hits leave the unit in break mode.
    a_hit_breaks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_out_kind == bwd_pkg::EV_BREAK) ||
                         (r_out_kind == bwd_pkg::EV_WATCH)))
        |-> (r_out_mode == bwd_pkg::MODE_BREAK))
        else $error("hit reported without entering break mode");

    // Exit is only reported while halted.
    a_exit_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == bwd_pkg::EV_EXIT))
        |-> (r_out_mode == bwd_pkg::MODE_HALT))
        else $error("exit reported outside halt mode");

    // The mode register moves only when a beat is decided.
    a_mode_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_mode))
        else $error("debug mode changed without a decided beat");

endmodule

/* rtl/core/bwd_addr_table.sv */
// Bounded address table with fill count and parallel match against all filled entries.
`timescale 1ns / 1ps

module bwd_addr_table #(
    parameter int ENTRIES = bwd_pkg::BREAK_ENTRIES_DEF,
    parameter int WIDTH   = bwd_pkg::ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_add,
    input  logic [WIDTH-1:0]     i_addr,
    output bwd_pkg::t_tab_status o_stat
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [WIDTH-1:0] r_entry [ENTRIES];
    logic [CNT_W-1:0] r_count;
    logic             full;
    logic             hit;

    assign full = (r_count == CNT_W'(ENTRIES));

    // Only entries below the fill count take part, so unwritten ones are never seen.
    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if ((CNT_W'(i) < r_count) && (r_entry[i] == i_addr)) begin
                hit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_add && !full) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_add && !full) begin
            r_entry[r_count[IDX_W-1:0]] <= i_addr;
        end
    end

    assign o_stat.hit  = hit;
    assign o_stat.full = full;

endmodule

/* dv/breakpoint_watch_debug_unit_tb.sv */
// Self-checking testbench for the breakpoint/watch debug unit: directed table, then random beats.
`timescale 1ns / 1ps

module breakpoint_watch_debug_unit_tb;

    localparam int ADDR_W = bwd_pkg::ADDR_W;

    // The unit is built with its default sizes, so the predictor uses the same ones.
    localparam int BP_DEPTH = bwd_pkg::BREAK_ENTRIES_DEF;
    localparam int WP_DEPTH = bwd_pkg::WATCH_ENTRIES_DEF;
    localparam logic [ADDR_W-1:0] ADDR_MASK =
        ADDR_W'((64'd1 << bwd_pkg::ADDR_BITS_DEF) - 1);

    localparam int RANDOM_BEATS   = 1350;
    localparam int BACKLOG_CYCLES = 64;
    localparam int WATCHDOG_LIMIT = 2000;

    // One result beat as the unit should present it.
    typedef struct packed {
        bwd_pkg::t_event   kind;
        logic [ADDR_W-1:0] addr;
        logic              status;
        bwd_pkg::t_mode    mode;
    } t_event_beat;

    // One row of the directed table. Where typed is set, want is the result read straight
    // off the behaviour; otherwise the predictor supplies the expectation.
    typedef struct packed {
        bwd_pkg::t_cmd     cmd;
        logic [ADDR_W-1:0] addr;
        logic              typed;
        t_event_beat       want;
    } t_dir_row;

    localparam t_event_beat FROM_PREDICTOR =
        '{bwd_pkg::EV_NONE, 16'h0000, 1'b0, bwd_pkg::MODE_RUN};
    localparam t_event_beat NONE_RUN =
        '{bwd_pkg::EV_NONE, 16'h0000, 1'b0, bwd_pkg::MODE_RUN};
    localparam t_event_beat BREAK_AT_1234 =
        '{bwd_pkg::EV_BREAK, 16'h1234, 1'b0, bwd_pkg::MODE_BREAK};
    localparam int DIR_ROWS = 25;

    // The opening rows start from the reset state, with empty tables, so their results are
    // plain to read, and add a duplicate entry. The later rows walk the mode changes, stepping,
    // the exit report, a watch hit that pulls halt back into break and a near-miss address.
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{bwd_pkg::CMD_FETCH,     16'h0000, 1'b1, NONE_RUN},
        '{bwd_pkg::CMD_ACCESS,    16'hFFFF, 1'b1, NONE_RUN},
        '{bwd_pkg::CMD_ADD_BREAK, 16'h1234, 1'b1, NONE_RUN},
        '{bwd_pkg::CMD_ADD_BREAK, 16'hFFFF, 1'b1, NONE_RUN},
        '{bwd_pkg::CMD_ADD_BREAK, 16'h1234, 1'b1, NONE_RUN},
        '{bwd_pkg::CMD_ADD_WATCH, 16'h0000, 1'b1, NONE_RUN},
        '{bwd_pkg::CMD_ADD_WATCH, 16'hFFFF, 1'b1, NONE_RUN},
        '{bwd_pkg::CMD_FETCH,     16'h1234, 1'b1, BREAK_AT_1234},
        '{bwd_pkg::CMD_FETCH,     16'h5555, 1'b0, FROM_PREDICTOR},
        '{bwd_pkg::CMD_FETCH,     16'hFFFF, 1'b0, FROM_PREDICTOR},
        '{bwd_pkg::CMD_STEP_ON,   16'h0000, 1'b0, FROM_PREDICTOR},
        '{bwd_pkg::CMD_FETCH,     16'hAAAA, 1'b0, FROM_PREDICTOR},
        '{bwd_pkg::CMD_RESUME,    16'hFFFF, 1'b0, FROM_PREDICTOR},
        '{bwd_pkg::CMD_ACCESS,    16'h0000, 1'b0, FROM_PREDICTOR},
        '{bwd_pkg::CMD_HALT,      16'h5555, 1'b0, FROM_PREDICTOR},
        '{bwd_pkg::CMD_FETCH,     16'h1234, 1'b0, FROM_PREDICTOR},
        '{bwd_pkg::CMD_ACCESS,    16'hFFFF, 1'b0, FROM_PREDICTOR},
        '{bwd_pkg::CMD_HALT,      16'hAAAA, 1'b0, FROM_PREDICTOR},
        '{bwd_pkg::CMD_ACCESS,    16'h1111, 1'b0, FROM_PREDICTOR},
        '{bwd_pkg::CMD_RESET,     16'h0000, 1'b0, FROM_PREDICTOR},
        '{bwd_pkg::CMD_STEP_ON,   16'hFFFF, 1'b0, FROM_PREDICTOR},
        '{bwd_pkg::CMD_RESET,     16'h5555, 1'b0, FROM_PREDICTOR},
        '{bwd_pkg::CMD_FETCH,     16'h1234, 1'b0, FROM_PREDICTOR},
        '{bwd_pkg::CMD_FETCH,     16'h0001, 1'b0, FROM_PREDICTOR},
        '{bwd_pkg::CMD_ACCESS,    16'h1235, 1'b0, FROM_PREDICTOR}
    };

    logic i_clk;
    logic i_rst_n;

    bwd_cmd_if cmd_if ();
    bwd_res_if evt_if ();

    breakpoint_watch_debug_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_evt   (evt_if)
    );

    // Predictor state: the two address tables, their fill levels, the mode and stepping.
    logic [ADDR_W-1:0] bp_addr [BP_DEPTH];
    int unsigned       bp_used;
    logic [ADDR_W-1:0] wp_addr [WP_DEPTH];
    int unsigned       wp_used;
    bwd_pkg::t_mode    dbg_mode;
    logic              stepping;

    // Results still owed by the unit, oldest first.
    t_event_beat pending_events [$];

    int unsigned mismatches;
    int unsigned quiet_cycles;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic        backlog_armed;

    // Works out the result of one accepted command beat and moves the predictor state on.
    // Only entries below the fill level are ever compared.
    function automatic t_event_beat predict_debug_event(bwd_pkg::t_cmd c,
                                                        logic [ADDR_W-1:0] raw);
        t_event_beat       r;
        logic [ADDR_W-1:0] a;
        logic              hit;
        a   = raw & ADDR_MASK;
        r   = '{bwd_pkg::EV_NONE, '0, 1'b0, bwd_pkg::MODE_RUN};
        hit = 1'b0;
        case (c)
            bwd_pkg::CMD_FETCH: begin
                if (dbg_mode == bwd_pkg::MODE_HALT) begin
                    r.kind = bwd_pkg::EV_EXIT;
                    r.addr = a;
                end else if (dbg_mode == bwd_pkg::MODE_BREAK) begin
                    if (stepping) begin
                        r.kind = bwd_pkg::EV_STEP;
                        r.addr = a;
                    end else begin
                        dbg_mode = bwd_pkg::MODE_RUN;
                    end
                end else begin
                    for (int i = 0; i < BP_DEPTH; i++)
                        if (i < bp_used && bp_addr[i] == a) hit = 1'b1;
                    if (hit) begin
                        dbg_mode = bwd_pkg::MODE_BREAK;
                        r.kind   = bwd_pkg::EV_BREAK;
                        r.addr   = a;
                    end
                end
            end
            bwd_pkg::CMD_ACCESS: begin
                // A watched access wins over every mode, halt included.
                for (int i = 0; i < WP_DEPTH; i++)
                    if (i < wp_used && wp_addr[i] == a) hit = 1'b1;
                if (hit) begin
                    dbg_mode = bwd_pkg::MODE_BREAK;
                    r.kind   = bwd_pkg::EV_WATCH;
                    r.addr   = a;
                end
            end
            bwd_pkg::CMD_ADD_BREAK: begin
                if (bp_used < BP_DEPTH) begin
                    bp_addr[bp_used] = a;
                    bp_used++;
                end else begin
                    r.status = 1'b1;
                end
            end
            bwd_pkg::CMD_ADD_WATCH: begin
                if (wp_used < WP_DEPTH) begin
                    wp_addr[wp_used] = a;
                    wp_used++;
                end else begin
                    r.status = 1'b1;
                end
            end
            bwd_pkg::CMD_STEP_ON: stepping = 1'b1;
            bwd_pkg::CMD_RESUME: begin
                stepping = 1'b0;
                dbg_mode = bwd_pkg::MODE_RUN;
            end
            bwd_pkg::CMD_HALT: dbg_mode = bwd_pkg::MODE_HALT;
            default: dbg_mode = bwd_pkg::MODE_RUN;   // the reset command keeps tables and stepping
        endcase
        r.mode = dbg_mode;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Offers one command beat from a falling edge, idling first at the current rate, and
    // returns at the falling edge after the beat has been taken. Exactly one assignment to
    // valid happens at any falling edge.
    task automatic send_command(input bwd_pkg::t_cmd c, input logic [ADDR_W-1:0] a,
                                input logic typed, input t_event_beat want);
        t_event_beat guess;
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= c;
        cmd_if.address <= a;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        guess = predict_debug_event(c, a);
        pending_events.push_back(typed ? want : guess);
        @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: ready changes on the falling edge. Once, at the start of the phase with
    // no idling, the receiver holds off for a long stretch so the unit backs up to its input.
    initial begin
        evt_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (backlog_armed) begin
                evt_if.ready <= 1'b0;
                repeat (BACKLOG_CYCLES - 1) @(negedge i_clk);
                backlog_armed = 1'b0;
            end else begin
                evt_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Result checker: every accepted beat is held against the oldest expectation.
    always @(posedge i_clk) begin
        t_event_beat want;
        if (i_rst_n && evt_if.valid && evt_if.ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected: kind %0d addr %h",
                                          evt_if.event_kind, evt_if.event_address));
            end else begin
                want = pending_events.pop_front();
                if (evt_if.event_kind !== want.kind)
                    report_mismatch($sformatf("event_kind %0d, expected %0d",
                                              evt_if.event_kind, want.kind));
                if (evt_if.event_address !== want.addr)
                    report_mismatch($sformatf("event_address %h, expected %h",
                                              evt_if.event_address, want.addr));
                if (evt_if.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              evt_if.status, want.status));
                if (evt_if.mode_now !== want.mode)
                    report_mismatch($sformatf("mode_now %0d, expected %0d",
                                              evt_if.mode_now, want.mode));
            end
        end
    end

    // Watchdog: a run of cycles in which no beat moves on either side ends the run.
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (evt_if.valid && evt_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        bwd_pkg::t_cmd     c;
        logic [ADDR_W-1:0] a;
        int unsigned       roll;

        i_rst_n        = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.command = bwd_pkg::CMD_FETCH;
        cmd_if.address = '0;
        bp_used        = 0;
        wp_used        = 0;
        dbg_mode       = bwd_pkg::MODE_RUN;
        stepping       = 1'b0;
        mismatches     = 0;
        quiet_cycles   = 0;
        backlog_armed  = 1'b0;
        send_idle_pct  = 29;
        recv_idle_pct  = 49;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_command(DIR_TABLE[r].cmd, DIR_TABLE[r].addr, DIR_TABLE[r].typed,
                         DIR_TABLE[r].want);

        // Random part. Adds are rare so the tables fill slowly and are then full for the
        // rest of the run; about half of the fetch and access addresses hit a live entry or one bit
        // off it, so the matching logic and the mode changes get plenty of exercise.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == RANDOM_BEATS / 3) begin
                send_idle_pct = 49;
                recv_idle_pct = 29;
            end
            if (n == 2 * RANDOM_BEATS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                backlog_armed = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 40)      c = bwd_pkg::CMD_FETCH;
            else if (roll < 65) c = bwd_pkg::CMD_ACCESS;
            else if (roll < 69) c = bwd_pkg::CMD_ADD_BREAK;
            else if (roll < 73) c = bwd_pkg::CMD_ADD_WATCH;
            else if (roll < 78) c = bwd_pkg::CMD_STEP_ON;
            else if (roll < 86) c = bwd_pkg::CMD_RESUME;
            else if (roll < 92) c = bwd_pkg::CMD_HALT;
            else                c = bwd_pkg::CMD_RESET;
            a    = ADDR_W'($urandom);
            roll = $urandom_range(99);
            if (c == bwd_pkg::CMD_FETCH && bp_used > 0 && roll < 50)
                a = bp_addr[$urandom_range(bp_used - 1)];
            else if (c == bwd_pkg::CMD_ACCESS && wp_used > 0 && roll < 50)
                a = wp_addr[$urandom_range(wp_used - 1)];
            if (roll >= 35 && roll < 50)
                a = a ^ (ADDR_W'(1) << $urandom_range(ADDR_W - 1));
            send_command(c, a, 1'b0, FROM_PREDICTOR);
        end
        cmd_if.valid <= 1'b0;

        // Drain, then keep the clock running to show any stray beat.
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
